FILE: rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, command and mode codes, and color step functions for the
// palette fade engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

    // Color word: red in [2:0], green in [5:3], blue in [8:6]
    typedef logic [8:0] t_color;
    typedef logic [2:0] t_level;
    typedef logic [2:0] t_cmd;
    typedef logic [2:0] t_kind;
    typedef logic [2:0] t_mode;
    typedef logic [1:0] t_chan;

    // Commands
    localparam t_cmd CMD_WR_TGT = 3'd0;
    localparam t_cmd CMD_WR_CUR = 3'd1;
    localparam t_cmd CMD_START  = 3'd2;
    localparam t_cmd CMD_TICK   = 3'd3;
    localparam t_cmd CMD_READ   = 3'd4;

    // Fade kinds on a start command
    localparam t_kind KIND_FROM_BLACK = 3'd0;
    localparam t_kind KIND_TO_BLACK   = 3'd1;
    localparam t_kind KIND_FROM_WHITE = 3'd2;
    localparam t_kind KIND_TO_WHITE   = 3'd3;
    localparam t_kind KIND_REVEAL     = 3'd4;
    localparam t_kind KIND_WASH       = 3'd5;

    // Fade modes (kind plus one)
    localparam t_mode MODE_IDLE       = 3'd0;
    localparam t_mode MODE_FROM_BLACK = 3'd1;
    localparam t_mode MODE_TO_BLACK   = 3'd2;
    localparam t_mode MODE_FROM_WHITE = 3'd3;
    localparam t_mode MODE_TO_WHITE   = 3'd4;
    localparam t_mode MODE_REVEAL     = 3'd5;
    localparam t_mode MODE_WASH       = 3'd6;

    // Channels
    localparam t_chan CH_RED   = 2'd0;
    localparam t_chan CH_GREEN = 2'd1;
    localparam t_chan CH_BLUE  = 2'd2;
    localparam t_chan PHASE_LAST_DONE = 2'd3;

    localparam t_level MAX_LEVEL   = 3'd7;
    localparam int     PHASE_TICKS = 8;
    localparam t_color COLOR_WHITE = 9'h1FF;
    localparam t_color COLOR_BLACK = 9'h000;

    // Configuration register map
    localparam int         APB_AW     = 4;
    localparam logic [1:0] REG_FIRST  = 2'd0;
    localparam logic [1:0] REG_LAST   = 2'd1;
    localparam logic [1:0] REG_SINGLE = 2'd2;

    function automatic t_level get_lvl(input t_color c, input t_chan ch);
        t_level v;
        unique case (ch)
            CH_RED:   v = c[2:0];
            CH_GREEN: v = c[5:3];
            default:  v = c[8:6];
        endcase
        return v;
    endfunction

    function automatic t_color set_lvl(input t_color c, input t_chan ch, input t_level v);
        t_color r;
        r = c;
        unique case (ch)
            CH_RED:   r[2:0] = v;
            CH_GREEN: r[5:3] = v;
            default:  r[8:6] = v;
        endcase
        return r;
    endfunction

    // One level toward the target, blue first, then green, then red
    function automatic t_color step_toward(input t_color cur, input t_color tgt,
                                           input logic up);
        t_color res;
        logic   hit;
        t_chan  ch;
        t_level c;
        t_level t;
        res = cur;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            ch = 2'(2 - k);
            c  = get_lvl(cur, ch);
            t  = get_lvl(tgt, ch);
            if (!hit && up && (t > c)) begin
                res = set_lvl(cur, ch, c + 3'd1);
                hit = 1'b1;
            end else if (!hit && !up && (t < c)) begin
                res = set_lvl(cur, ch, c - 3'd1);
                hit = 1'b1;
            end
        end
        return res;
    endfunction

    // One level toward black or white, red first, then green, then blue
    function automatic t_color step_extreme(input t_color cur, input logic up);
        t_color res;
        logic   hit;
        t_chan  ch;
        t_level c;
        res = cur;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            ch = 2'(k);
            c  = get_lvl(cur, ch);
            if (!hit && up && (c != MAX_LEVEL)) begin
                res = set_lvl(cur, ch, c + 3'd1);
                hit = 1'b1;
            end else if (!hit && !up && (c != 3'd0)) begin
                res = set_lvl(cur, ch, c - 3'd1);
                hit = 1'b1;
            end
        end
        return res;
    endfunction

    // Phase channel update: reveal takes max(saved, mask), wash raises by one
    function automatic t_color phase_step(input t_color cur, input t_color sav,
                                          input t_chan ch, input t_level mask,
                                          input logic reveal);
        t_level s;
        t_level c;
        t_color res;
        s   = get_lvl(sav, ch);
        c   = get_lvl(cur, ch);
        res = cur;
        if (reveal) begin
            res = set_lvl(cur, ch, (s < mask) ? mask : s);
        end else if (c < MAX_LEVEL) begin
            res = set_lvl(cur, ch, c + 3'd1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pfe_cmd_if.sv
// ----------------------------------------------------------------------------
// pfe_cmd_if
// Command channel: valid/ready handshake with one command per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic       bank;
    logic [5:0] index;
    logic [2:0] red;
    logic [2:0] green;
    logic [2:0] blue;
    logic [2:0] fade_kind;

    modport source (
        output valid, command, bank, index, red, green, blue, fade_kind,
        input  ready
    );
    modport sink (
        input  valid, command, bank, index, red, green, blue, fade_kind,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/pfe_res_if.sv
// ----------------------------------------------------------------------------
// pfe_res_if
// Result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_res_if;
    logic       valid;
    logic       ready;
    logic       done_res;
    logic [2:0] out_red;
    logic [2:0] out_green;
    logic [2:0] out_blue;

    modport source (
        output valid, done_res, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, done_res, out_red, out_green, out_blue,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that updates only on a read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 128
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/palette_fade_engine.sv
// ----------------------------------------------------------------------------
// palette_fade_engine
// Palette fade engine with current, target and saved color banks in RAM.
//
// Usage:
//   i_cmd carries one command per transaction (write target, write current,
//   start fade, frame tick, read current); o_res returns exactly one result
//   per command: the done flag and, for a read, the three color levels.
//   The APB port sets first_entry, last_offset and single_bank; write it
//   only while no command is in flight.
//   Writes, reads and starts that need no sweep go from acceptance through
//   ST_FIN into the output register. Sweeping commands first pass through
//   ST_SWEEP once per palette entry touched (at most 2*ENTRIES for a tick
//   of a basic fade, ENTRIES for reveal/wash work ticks, reveal start and
//   from-black/from-white start). The sweep reads one entry per cycle
//   from the current palette RAM and writes it back in the next cycle;
//   that single read port sets the rate. One command is worked at a time;
//   the next is accepted once its result is in the output register, even
//   while it waits there. If o_res stalls, the finished command holds
//   until taken. Reset returns the fade state to idle and the registers
//   to their defaults; palette RAM contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_fade_engine #(
    parameter int ENTRIES    = 64,
    parameter int FADE_TICKS = 22
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    pfe_cmd_if.sink                    i_cmd,
    pfe_res_if.source                  o_res,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [pfe_pkg::APB_AW-1:0]  paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import pfe_pkg::*;

    localparam int EW  = $clog2(ENTRIES);
    localparam int AW  = $clog2(2 * ENTRIES);
    localparam int RW  = (EW > 7) ? EW + 1 : 8;
    localparam int SWB = ($clog2(FADE_TICKS + 1) > 4) ? $clog2(FADE_TICKS + 1) : 4;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_FIN   = 2'd2;

    // Sweep operations
    localparam logic [1:0] SW_SET   = 2'd0;
    localparam logic [1:0] SW_SNAP  = 2'd1;
    localparam logic [1:0] SW_BASIC = 2'd2;
    localparam logic [1:0] SW_PHASE = 2'd3;

    // index modulo the entry count (index < 64, ENTRIES >= 16)
    function automatic logic [EW-1:0] idx_mod(input logic [5:0] v);
        logic [8:0] t;
        t = 9'(v);
        for (int k = 0; k < 4; k++) begin
            if (t >= 9'(ENTRIES)) begin
                t = t - 9'(ENTRIES);
            end
        end
        return EW'(t);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic b, input logic [EW-1:0] e);
        return AW'(e) + (b ? AW'(ENTRIES) : AW'(0));
    endfunction

    // Configuration registers
    logic [5:0] r_first;
    logic [5:0] r_last;
    logic       r_single;

    // Fade control state
    logic [1:0]     r_state, n_state;
    t_mode          r_mode, n_mode;
    logic [SWB-1:0] r_step, n_step;
    t_chan          r_phase, n_phase;
    t_level         r_mask, n_mask;

    // Sweep control
    logic [1:0]    r_sw_op, n_sw_op;
    t_mode         r_sw_mode, n_sw_mode;
    t_chan         r_sw_ch, n_sw_ch;
    t_level        r_sw_mask, n_sw_mask;
    logic          r_sw_white, n_sw_white;
    logic          r_two, n_two;
    logic          r_bank, n_bank;
    logic [RW-1:0] r_idx, n_idx;
    logic [RW-1:0] r_start, n_start;
    logic [RW-1:0] r_end, n_end;

    // Write-back stage
    logic          r_p_valid, n_p_valid;
    logic [AW-1:0] r_p_addr, n_p_addr;
    logic [EW-1:0] r_p_ent, n_p_ent;

    // Pending result
    logic r_res_done, n_res_done;
    logic r_res_read, n_res_read;

    // Output register
    logic   r_out_valid;
    logic   r_out_done;
    t_level r_out_r, r_out_g, r_out_b;
    logic   out_load;

    // RAM ports
    logic          cur_we, cur_re, tgt_we, tgt_re, sav_we, sav_re;
    logic [AW-1:0] cur_waddr, cur_raddr, tgt_waddr, tgt_raddr;
    logic [EW-1:0] sav_waddr, sav_raddr;
    t_color        cur_wdata, tgt_wdata, sav_wdata;
    t_color        cur_rdata, tgt_rdata, sav_rdata;

    // Command decode
    logic          cmd_fire;
    logic [EW-1:0] ent_in;
    logic [AW-1:0] addr_in;
    t_color        color_in;
    logic [RW-1:0] sum_w, range_start, range_end;
    logic          range_empty;
    logic          do_sweep;
    logic          done_t;
    logic [SWB:0]  step_inc;

    assign cmd_fire = i_cmd.valid && i_cmd.ready;
    assign ent_in   = idx_mod(i_cmd.index);
    assign addr_in  = addr_of(i_cmd.bank, ent_in);
    assign color_in = {i_cmd.blue, i_cmd.green, i_cmd.red};

    // covered entry range of the basic fades, end clamped to the last entry
    assign sum_w       = RW'(r_first) + RW'(r_last);
    assign range_end   = (sum_w > RW'(ENTRIES - 1)) ? RW'(ENTRIES - 1) : sum_w;
    assign range_start = RW'(r_first);
    assign range_empty = range_start > range_end;
    assign step_inc    = (SWB + 1)'(r_step) + (SWB + 1)'(1);

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign out_load    = (r_state == ST_FIN) && (!r_out_valid || o_res.ready);

    // Sequencer, command execution and RAM port control
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_step     = r_step;
        n_phase    = r_phase;
        n_mask     = r_mask;
        n_sw_op    = r_sw_op;
        n_sw_mode  = r_sw_mode;
        n_sw_ch    = r_sw_ch;
        n_sw_mask  = r_sw_mask;
        n_sw_white = r_sw_white;
        n_two      = r_two;
        n_bank     = r_bank;
        n_idx      = r_idx;
        n_start    = r_start;
        n_end      = r_end;
        n_p_valid  = 1'b0;
        n_p_addr   = r_p_addr;
        n_p_ent    = r_p_ent;
        n_res_done = r_res_done;
        n_res_read = r_res_read;
        do_sweep   = 1'b0;
        done_t     = 1'b0;
        cur_we = 1'b0; cur_waddr = addr_in; cur_wdata = color_in;
        tgt_we = 1'b0; tgt_waddr = addr_in; tgt_wdata = color_in;
        sav_we = 1'b0; sav_waddr = r_p_ent; sav_wdata = cur_rdata;
        cur_re = 1'b0; cur_raddr = addr_in;
        tgt_re = 1'b0; tgt_raddr = addr_in;
        sav_re = 1'b0; sav_raddr = r_idx[EW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (cmd_fire) begin
                    n_state    = ST_FIN;
                    n_res_read = (i_cmd.command == CMD_READ);
                    unique case (i_cmd.command)
                        CMD_WR_TGT: tgt_we = 1'b1;
                        CMD_WR_CUR: cur_we = 1'b1;
                        CMD_READ:   cur_re = 1'b1;
                        CMD_START: begin
                            if (i_cmd.fade_kind <= KIND_WASH) begin
                                n_mode  = i_cmd.fade_kind + 3'd1;
                                n_phase = CH_RED;
                                if (i_cmd.fade_kind <= KIND_TO_WHITE) begin
                                    n_step = '0;
                                    if (i_cmd.fade_kind == KIND_FROM_BLACK ||
                                        i_cmd.fade_kind == KIND_FROM_WHITE) begin
                                        n_sw_op    = SW_SET;
                                        n_sw_white = (i_cmd.fade_kind == KIND_FROM_WHITE);
                                        n_start    = range_start;
                                        n_end      = range_end;
                                        n_two      = 1'b0;
                                        do_sweep   = !range_empty;
                                    end
                                end else begin
                                    n_step = SWB'(PHASE_TICKS);
                                    if (i_cmd.fade_kind == KIND_REVEAL) begin
                                        n_mask   = MAX_LEVEL;
                                        n_sw_op  = SW_SNAP;
                                        n_start  = '0;
                                        n_end    = RW'(ENTRIES - 1);
                                        n_two    = 1'b0;
                                        do_sweep = 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_TICK: begin
                            if (r_mode == MODE_IDLE) begin
                                done_t = 1'b1;
                            end else if (r_mode <= MODE_TO_WHITE) begin
                                n_sw_op   = SW_BASIC;
                                n_sw_mode = r_mode;
                                n_start   = range_start;
                                n_end     = range_end;
                                n_two     = !(r_single && (r_mode == MODE_FROM_BLACK ||
                                                           r_mode == MODE_FROM_WHITE));
                                do_sweep  = !range_empty;
                                if (step_inc >= (SWB + 1)'(FADE_TICKS)) begin
                                    n_step = '0;
                                    n_mode = MODE_IDLE;
                                    done_t = 1'b1;
                                end else begin
                                    n_step = step_inc[SWB-1:0];
                                end
                            end else if (r_phase == PHASE_LAST_DONE) begin
                                n_mode = MODE_IDLE;
                            end else if (r_step != '0) begin
                                n_step    = r_step - SWB'(1);
                                n_sw_op   = SW_PHASE;
                                n_sw_mode = r_mode;
                                n_sw_ch   = r_phase;
                                n_sw_mask = r_mask;
                                n_start   = '0;
                                n_end     = RW'(ENTRIES - 1);
                                n_two     = 1'b0;
                                do_sweep  = 1'b1;
                                if (r_mode == MODE_REVEAL) begin
                                    n_mask = r_mask - 3'd1;
                                end
                            end else begin
                                n_step  = SWB'(PHASE_TICKS);
                                n_phase = r_phase + 2'd1;
                                if (r_mode == MODE_REVEAL) begin
                                    n_mask = MAX_LEVEL;
                                end
                            end
                        end
                        default: ;
                    endcase
                    n_res_done = (i_cmd.command == CMD_TICK) ? done_t
                                                             : (n_mode == MODE_IDLE);
                    if (do_sweep) begin
                        n_state = ST_SWEEP;
                        n_bank  = 1'b0;
                        n_idx   = n_start;
                    end
                end
            end
            ST_SWEEP: begin
                // issue reads for one entry; write-back follows next cycle
                cur_re    = 1'b1;
                tgt_re    = 1'b1;
                sav_re    = 1'b1;
                cur_raddr = addr_of(r_bank, r_idx[EW-1:0]);
                tgt_raddr = addr_of(r_bank, r_idx[EW-1:0]);
                n_p_valid = 1'b1;
                n_p_addr  = addr_of(r_bank, r_idx[EW-1:0]);
                n_p_ent   = r_idx[EW-1:0];
                if (r_idx == r_end) begin
                    if (!r_bank && r_two) begin
                        n_bank = 1'b1;
                        n_idx  = r_start;
                    end else begin
                        n_state = ST_FIN;
                    end
                end else begin
                    n_idx = r_idx + RW'(1);
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // write-back of the swept entry
        if (r_p_valid) begin
            cur_we    = 1'b1;
            cur_waddr = r_p_addr;
            unique case (r_sw_op)
                SW_SET:  cur_wdata = r_sw_white ? COLOR_WHITE : COLOR_BLACK;
                SW_SNAP: begin
                    sav_we    = 1'b1;
                    cur_wdata = COLOR_WHITE;
                end
                SW_BASIC: begin
                    unique case (r_sw_mode)
                        MODE_FROM_BLACK: cur_wdata = step_toward(cur_rdata, tgt_rdata, 1'b1);
                        MODE_FROM_WHITE: cur_wdata = step_toward(cur_rdata, tgt_rdata, 1'b0);
                        MODE_TO_BLACK:   cur_wdata = step_extreme(cur_rdata, 1'b0);
                        default:         cur_wdata = step_extreme(cur_rdata, 1'b1);
                    endcase
                end
                SW_PHASE: cur_wdata = phase_step(cur_rdata, sav_rdata, r_sw_ch, r_sw_mask,
                                                 r_sw_mode == MODE_REVEAL);
                default: ;
            endcase
        end
    end

    // Palette memories
    pfe_ram #(.WIDTH(9), .DEPTH(2 * ENTRIES)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_re    (cur_re),
        .i_raddr (cur_raddr),
        .o_rdata (cur_rdata)
    );

    pfe_ram #(.WIDTH(9), .DEPTH(2 * ENTRIES)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (tgt_waddr),
        .i_wdata (tgt_wdata),
        .i_re    (tgt_re),
        .i_raddr (tgt_raddr),
        .o_rdata (tgt_rdata)
    );

    pfe_ram #(.WIDTH(9), .DEPTH(ENTRIES)) u_sav_ram (
        .i_clk   (i_clk),
        .i_we    (sav_we),
        .i_waddr (sav_waddr),
        .i_wdata (sav_wdata),
        .i_re    (sav_re),
        .i_raddr (sav_raddr),
        .o_rdata (sav_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_IDLE;
            r_step      <= '0;
            r_phase     <= CH_RED;
            r_mask      <= MAX_LEVEL;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_step    <= n_step;
            r_phase   <= n_phase;
            r_mask    <= n_mask;
            r_p_valid <= n_p_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sweep and result payload registers
    always_ff @(posedge i_clk) begin
        r_sw_op    <= n_sw_op;
        r_sw_mode  <= n_sw_mode;
        r_sw_ch    <= n_sw_ch;
        r_sw_mask  <= n_sw_mask;
        r_sw_white <= n_sw_white;
        r_two      <= n_two;
        r_bank     <= n_bank;
        r_idx      <= n_idx;
        r_start    <= n_start;
        r_end      <= n_end;
        r_p_addr   <= n_p_addr;
        r_p_ent    <= n_p_ent;
        r_res_done <= n_res_done;
        r_res_read <= n_res_read;
        if (out_load) begin
            r_out_done <= r_res_done;
            r_out_r    <= r_res_read ? get_lvl(cur_rdata, CH_RED)   : 3'd0;
            r_out_g    <= r_res_read ? get_lvl(cur_rdata, CH_GREEN) : 3'd0;
            r_out_b    <= r_res_read ? get_lvl(cur_rdata, CH_BLUE)  : 3'd0;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.done_res  = r_out_done;
    assign o_res.out_red   = r_out_r;
    assign o_res.out_green = r_out_g;
    assign o_res.out_blue  = r_out_b;

    // APB configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 6'd0;
            r_last   <= 6'd63;
            r_single <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_FIRST:  r_first  <= pwdata[5:0];
                REG_LAST:   r_last   <= pwdata[5:0];
                REG_SINGLE: r_single <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_FIRST:  prdata = {26'd0, r_first};
            REG_LAST:   prdata = {26'd0, r_last};
            REG_SINGLE: prdata = {31'd0, r_single};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire
